>>> sv/hahq_pkg.sv
`timescale 1ns / 1ps
// Package for the humidity averaging qualifier.
// Holds the item structs, lane result type, register indexes and widths; no dependencies.
package hahq_pkg;

	localparam int ATTEMPTS  = 3;
	localparam int NUM_LANES = (ATTEMPTS < 3) ? ATTEMPTS : 3;

	localparam int SAMPLE_W = 12;
	localparam int HUM_W    = 10;
	localparam int SUM_W    = 12;
	localparam int CNT_W    = 2;
	localparam int OFFS_W   = 9;
	localparam int TIME_W   = 32;
	localparam int LIMIT_W  = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [HUM_W-1:0]  HUM_MAX       = 10'd1000;
	localparam logic [HUM_W-1:0]  HUM_RESET     = 10'd500;
	localparam logic [TIME_W-1:0] THROTTLE_RESET = 32'd60000;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 8'd5;

	// floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT, exact for x up to 3000
	localparam int RECIP3_SHIFT = 17;
	localparam logic [16:0] RECIP3 = 17'd43691;

	localparam logic [CFG_IDX_W-1:0] CFG_CALIB_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_THROTTLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT   = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0]          now_ms;
		logic signed [SAMPLE_W-1:0] sample_a;
		logic                       sample_a_ok;
		logic signed [SAMPLE_W-1:0] sample_b;
		logic                       sample_b_ok;
		logic signed [SAMPLE_W-1:0] sample_c;
		logic                       sample_c_ok;
	} in_item_t;

	typedef struct packed {
		logic [HUM_W-1:0] humidity;
		logic             humidity_valid;
		logic [CNT_W-1:0] good_count;
		logic             error_raised;
	} out_item_t;

	typedef struct packed {
		logic             good;
		logic [HUM_W-1:0] value;
	} lane_res_t;

endpackage

>>> sv/humidity_average_hold_qualifier.sv
`timescale 1ns / 1ps
// Top level of the humidity averaging qualifier with stale hold and throttled error.
// Depends on hahq_pkg, hahq_lane, hahq_merge and hahq_div.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one poll cycle per item:
//   a millisecond timestamp and three humidity attempts with present flags.
//   Output channel (out_valid / out_stall / out_data) returns one item per input:
//   the held humidity, its valid flag, the number of attempts used and an error flag.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_wdata) writes the
//   calibration offset (0), error throttle in ms (1) and failure limit (2);
//   cfg_ready is always high, and writes belong in idle periods.
//   An accepted item moves through the qualify, merge, divide and update stages in order;
//   the block holds one item at a time and takes no new item until the last one reaches
//   the output register, since each item updates the held value, bad-cycle counter and
//   error timestamp that the next item reads.
//   A stalled result sits in the output register; the final stage waits for it,
//   and in_stall stays high until the item in flight reaches the output register.
//   Reset: held humidity 50.0 %, bad-cycle counter and last error time zero,
//   offset zero, throttle 60000 ms, failure limit 5; no item in flight.
module humidity_average_hold_qualifier import hahq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_wdata
);

	// sequencing flags
	logic busy_q;
	logic v1_q, v2_q, v3_q;
	logic out_valid_q;
	out_item_t out_data_q;

	// configuration registers
	logic signed [OFFS_W-1:0] calib_offset_q;
	logic [TIME_W-1:0]        throttle_q;
	logic [LIMIT_W-1:0]       limit_q;

	// block state
	logic [HUM_W-1:0]   held_q;
	logic [LIMIT_W-1:0] bad_cycles_q;
	logic [TIME_W-1:0]  last_err_q;

	// timestamp of the item in flight
	logic [TIME_W-1:0]  now_q;

	logic accept;
	logic fire;

	logic signed [SAMPLE_W-1:0] lane_sample [NUM_LANES];
	logic                       lane_ok     [NUM_LANES];
	lane_res_t [NUM_LANES-1:0]  lane_res_s1;

	logic [SUM_W-1:0] sum_s2;
	logic [CNT_W-1:0] cnt_s2;
	logic [HUM_W-1:0] quo_s3;
	logic [CNT_W-1:0] cnt_s3;

	logic signed [SAMPLE_W-1:0] adj;
	logic [HUM_W-1:0]           clamped;
	logic [LIMIT_W-1:0]         bad_next;
	logic [TIME_W-1:0]          elapsed;
	logic                       err_d;
	logic                       good_d;

	assign accept    = in_valid && !busy_q;
	assign in_stall  = busy_q;
	assign cfg_ready = 1'b1;
	assign fire      = v3_q && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// route the attempt fields onto the lanes in order
	always_comb begin
		logic signed [SAMPLE_W-1:0] s [3];
		logic                       k [3];
		s[0] = in_data.sample_a;  k[0] = in_data.sample_a_ok;
		s[1] = in_data.sample_b;  k[1] = in_data.sample_b_ok;
		s[2] = in_data.sample_c;  k[2] = in_data.sample_c_ok;
		for (int i = 0; i < NUM_LANES; i++) begin
			lane_sample[i] = s[i];
			lane_ok[i]     = k[i];
		end
	end

	genvar g;
	generate
		for (g = 0; g < NUM_LANES; g++) begin : g_lane
			hahq_lane u_lane (
				.clk       (clk),
				.en        (accept),
				.sample    (lane_sample[g]),
				.sample_ok (lane_ok[g]),
				.res_s1    (lane_res_s1[g])
			);
		end
	endgenerate

	hahq_merge u_merge (
		.clk    (clk),
		.en     (v1_q),
		.lanes  (lane_res_s1),
		.sum_s2 (sum_s2),
		.cnt_s2 (cnt_s2)
	);

	hahq_div u_div (
		.clk    (clk),
		.en     (v2_q),
		.sum    (sum_s2),
		.cnt    (cnt_s2),
		.quo_s3 (quo_s3),
		.cnt_s3 (cnt_s3)
	);

	// Final stage: apply offset and clamp on a good cycle, else advance the
	// bad-cycle counter and check the throttle window with wrapping time.
	always_comb begin
		good_d  = (cnt_s3 != '0);
		adj     = $signed({2'b00, quo_s3}) + SAMPLE_W'(calib_offset_q);
		if (adj < 0) begin
			clamped = '0;
		end else if (adj > $signed({2'b00, HUM_MAX})) begin
			clamped = HUM_MAX;
		end else begin
			clamped = adj[HUM_W-1:0];
		end
		bad_next = (bad_cycles_q == '1) ? bad_cycles_q : bad_cycles_q + LIMIT_W'(1);
		elapsed  = now_q - last_err_q;
		err_d    = !good_d && (bad_next >= limit_q) && (elapsed > throttle_q);
	end

	// hold the timestamp of the item in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= in_data.now_ms;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q.humidity       <= good_d ? clamped : held_q;
			out_data_q.humidity_valid <= good_d;
			out_data_q.good_count     <= cnt_s3;
			out_data_q.error_raised   <= err_d;
		end
	end

	// sequencing: one item moves through the four stages at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v1_q <= accept;
			v2_q <= v1_q;
			if (v2_q) begin
				v3_q <= 1'b1;
			end else if (fire) begin
				v3_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// held value, bad-cycle counter and error timestamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= HUM_RESET;
			bad_cycles_q <= '0;
			last_err_q   <= '0;
		end else if (fire) begin
			if (good_d) begin
				held_q       <= clamped;
				bad_cycles_q <= '0;
			end else begin
				bad_cycles_q <= bad_next;
				if (err_d) begin
					last_err_q <= now_q;
				end
			end
		end
	end

	// configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_offset_q <= '0;
			throttle_q     <= THROTTLE_RESET;
			limit_q        <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CALIB_OFFSET: calib_offset_q <= cfg_wdata[OFFS_W-1:0];
				CFG_ERR_THROTTLE: throttle_q     <= cfg_wdata[TIME_W-1:0];
				CFG_FAIL_LIMIT:   limit_q        <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

>>> sv/hahq_lane.sv
`timescale 1ns / 1ps
// One qualifying lane: checks a single humidity attempt and registers the verdict.
// Depends on hahq_pkg.
module hahq_lane import hahq_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       sample_ok,
	output lane_res_t                  res_s1
);

	logic in_range;

	assign in_range = (sample >= 0) && (sample <= $signed({2'b00, HUM_MAX}));

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1.good  <= sample_ok && in_range;
			res_s1.value <= sample[HUM_W-1:0];
		end
	end

endmodule

>>> sv/hahq_merge.sv
`timescale 1ns / 1ps
// Merge stage: adds up the good lanes and counts them.
// Depends on hahq_pkg.
module hahq_merge import hahq_pkg::*; (
	input  logic                        clk,
	input  logic                        en,
	input  lane_res_t [NUM_LANES-1:0]   lanes,
	output logic [SUM_W-1:0]            sum_s2,
	output logic [CNT_W-1:0]            cnt_s2
);

	logic [SUM_W-1:0] sum_d;
	logic [CNT_W-1:0] cnt_d;

	always_comb begin
		sum_d = '0;
		cnt_d = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			if (lanes[i].good) begin
				sum_d = sum_d + SUM_W'(lanes[i].value);
				cnt_d = cnt_d + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sum_d;
			cnt_s2 <= cnt_d;
		end
	end

endmodule

>>> sv/hahq_div.sv
`timescale 1ns / 1ps
// Small divider: truncating quotient of the lane sum by a count of one to three; a count of zero gives zero.
// Depends on hahq_pkg.
module hahq_div import hahq_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [SUM_W-1:0] sum,
	input  logic [CNT_W-1:0] cnt,
	output logic [HUM_W-1:0] quo_s3,
	output logic [CNT_W-1:0] cnt_s3
);

	logic [SUM_W+17-1:0] prod;
	logic [SUM_W-1:0]    quo_d;

	assign prod = (SUM_W+17)'(sum) * (SUM_W+17)'(RECIP3);

	always_comb begin
		case (cnt)
			2'd1:    quo_d = sum;
			2'd2:    quo_d = sum >> 1;
			2'd3:    quo_d = prod[RECIP3_SHIFT +: SUM_W];
			default: quo_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s3 <= quo_d[HUM_W-1:0];
			cnt_s3 <= cnt;
		end
	end

endmodule
